FILE: src/compacting_keyed_table_unit_macros.svh
// Assertion macros for the compacting keyed table unit checker.
// Included by the checker file only; needs no package.
`ifndef COMPACTING_KEYED_TABLE_UNIT_MACROS_SVH
`define COMPACTING_KEYED_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CKT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CKT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/ckt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the compacting keyed table unit.
// No dependencies; imported by the cell, the top level and the checker.
package ckt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_W       = 32;
    localparam int PRICE_W     = 32;
    localparam int CFG_W       = 5;
    localparam int TOTAL_W     = 5;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int LIM_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(10);

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_FIND   = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // Broadcast to every cell during the execute cycle.
    typedef struct packed {
        logic               remove;
        logic [KEY_W-1:0]   key;
        logic [PRICE_W-1:0] price;
    } t_cell_cmd;

endpackage

FILE: src/ckt_cell.sv
`timescale 1ns / 1ps
// One table slot: holds a key and price word, compares against the broadcast key,
// and takes its upper neighbor's entry when a removal closes the gap. Uses ckt_pkg.
module ckt_cell
    import ckt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_live,       // slot index below entry count
    input  logic               i_load,       // append lands in this slot
    input  t_cell_cmd          i_cmd,
    input  logic [KEY_W-1:0]   i_next_key,
    input  logic [PRICE_W-1:0] i_next_price,
    input  logic               i_hit_before, // a lower slot already matched
    output logic [KEY_W-1:0]   o_key,
    output logic [PRICE_W-1:0] o_price,
    output logic               o_first,      // first match is this slot
    output logic               o_hit_thru
);

    logic [KEY_W-1:0]   r_key;
    logic [PRICE_W-1:0] r_price;
    logic               match;
    logic               shift;

    always_comb begin
        match      = i_live && (r_key == i_cmd.key);
        o_first    = match && !i_hit_before;
        o_hit_thru = i_hit_before || match;
        // slots at and above the removed one pull from above
        shift      = i_cmd.remove && o_hit_thru;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_key   <= i_cmd.key;
            r_price <= i_cmd.price;
        end else if (shift) begin
            r_key   <= i_next_key;
            r_price <= i_next_price;
        end
    end

    assign o_key   = r_key;
    assign o_price = r_price;

endmodule

FILE: src/compacting_keyed_table_unit.sv
`timescale 1ns / 1ps
// Compacting keyed table unit: top level with the command register, the row of
// table cells and the result register. Uses ckt_pkg and ckt_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries mode, item_key, price_bits.
//   Output channel (o_out_valid / i_out_ready) returns one result per input:
//   status, found_key, found_price_bits and the entry count after the operation.
//   Config channel (i_cfg_valid / o_cfg_ready) writes capacity_limit; always ready.
//   Timing: a transaction is registered at acceptance; all cells compare and
//   shift in the execute cycle, which waits while a result is stalled, and the
//   result is registered at its end. The input side is ready again after
//   execute, so a new one waits until the last has executed, as set by the
//   command register feeding the cell row and the entry count update.
//   Receiver stall: a waiting result sits in the output register; one more
//   transaction is taken and held in the command register until it drains.
//   Reset (synchronous, active low) empties the table, sets capacity to 10 and
//   drops output valid and busy. Table contents are not cleared; the count masks them.
module compacting_keyed_table_unit
    import ckt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_mode,
    input  logic signed [KEY_W-1:0]   i_item_key,
    input  logic [PRICE_W-1:0]        i_price_bits,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_status,
    output logic signed [KEY_W-1:0]   o_found_key,
    output logic [PRICE_W-1:0]        o_found_price_bits,
    output logic [TOTAL_W-1:0]        o_entry_total,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_W-1:0]          i_cfg_capacity_limit
);

    // command register
    logic               r_busy;
    t_mode              r_mode;
    logic [KEY_W-1:0]   r_key;
    logic [PRICE_W-1:0] r_price;

    logic [CFG_W-1:0]   r_cap;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    // result register
    logic               r_out_valid;
    t_status            r_status;
    t_status            n_status;
    logic [KEY_W-1:0]   r_fkey;
    logic [KEY_W-1:0]   n_fkey;
    logic [PRICE_W-1:0] r_fprice;
    logic [PRICE_W-1:0] n_fprice;
    logic [TOTAL_W-1:0] r_total;

    logic               exec;
    logic               full;
    logic               found;
    logic [LIM_W-1:0]   cap_ext;
    logic [LIM_W-1:0]   depth_ext;
    logic [LIM_W-1:0]   limit;
    t_cell_cmd          cmd;

    logic [KEY_W-1:0]   cell_key   [TABLE_DEPTH];
    logic [PRICE_W-1:0] cell_price [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_first;
    logic [TABLE_DEPTH-1:0] cell_hit;

    assign o_in_ready  = !r_busy;
    assign o_cfg_ready = 1'b1;
    assign exec        = r_busy && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_busy <= 1'b1;
        end else if (exec) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_mode  <= t_mode'(i_mode);
            r_key   <= $unsigned(i_item_key);
            r_price <= i_price_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_capacity_limit;
        end
    end

    always_comb begin
        cmd.remove = exec && (r_mode == MODE_REMOVE);
        cmd.key    = r_key;
        cmd.price  = r_price;
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            logic               live;
            logic               load;
            logic               hit_before;
            logic [KEY_W-1:0]   next_key;
            logic [PRICE_W-1:0] next_price;

            assign live = CNT_W'(gi) < r_count;
            assign load = exec && (r_mode == MODE_ADD) && !full && (r_count == CNT_W'(gi));

            if (gi == 0) begin : g_head
                assign hit_before = 1'b0;
            end else begin : g_link
                assign hit_before = cell_hit[gi-1];
            end

            if (gi == TABLE_DEPTH - 1) begin : g_tail
                // top slot falls out of the live range after a removal
                assign next_key   = '0;
                assign next_price = '0;
            end else begin : g_up
                assign next_key   = cell_key[gi+1];
                assign next_price = cell_price[gi+1];
            end

            ckt_cell u_cell (
                .i_clk        (i_clk),
                .i_live       (live),
                .i_load       (load),
                .i_cmd        (cmd),
                .i_next_key   (next_key),
                .i_next_price (next_price),
                .i_hit_before (hit_before),
                .o_key        (cell_key[gi]),
                .o_price      (cell_price[gi]),
                .o_first      (cell_first[gi]),
                .o_hit_thru   (cell_hit[gi])
            );
        end
    endgenerate

    always_comb begin
        cap_ext   = LIM_W'(r_cap);
        depth_ext = LIM_W'(TABLE_DEPTH);
        limit     = (cap_ext < depth_ext) ? cap_ext : depth_ext;
        full      = LIM_W'(r_count) >= limit;
        found     = cell_hit[TABLE_DEPTH-1];
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        n_fkey   = '0;
        n_fprice = '0;
        case (r_mode)
            MODE_ADD: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            MODE_REMOVE, MODE_FIND: begin
                if (!found) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    // one-hot select of the first matching slot
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        n_fkey   = n_fkey   | ({KEY_W{cell_first[i]}}   & cell_key[i]);
                        n_fprice = n_fprice | ({PRICE_W{cell_first[i]}} & cell_price[i]);
                    end
                    if (r_mode == MODE_REMOVE) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_count     <= n_count;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_status <= n_status;
            r_fkey   <= n_fkey;
            r_fprice <= n_fprice;
            r_total  <= TOTAL_W'(n_count);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_found_key        = $signed(r_fkey);
    assign o_found_price_bits = r_fprice;
    assign o_entry_total      = r_total;

endmodule

FILE: src/ckt_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the compacting keyed table unit, bound to the top level.
// Uses ckt_pkg and the assertion macros header.
`include "compacting_keyed_table_unit_macros.svh"

module ckt_chk
    import ckt_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [1:0]              o_status,
    input logic signed [KEY_W-1:0] o_found_key,
    input logic [PRICE_W-1:0]      o_found_price_bits,
    input logic [TOTAL_W-1:0]      o_entry_total
);

    // stalled result stays posted
    `CKT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")

    // one transaction in flight: input side closes after acceptance
    `CKT_ASSERT_NEXT(a_in_close, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input ready right after a transaction")

    `CKT_ASSERT_NOW(a_total_max, i_clk, i_rst_n, o_out_valid, o_entry_total <= TOTAL_W'(TABLE_DEPTH), "entry total above table depth")

    // full or missed lookups report no entry
    `CKT_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_out_valid && (o_status == ST_FULL || o_status == ST_NOT_FOUND), o_found_key == '0 && o_found_price_bits == '0, "nonzero found fields without a hit")

endmodule

bind compacting_keyed_table_unit ckt_chk u_ckt_chk (.*);
